[rtl/sha1_pkg.sv]
// Shared types and constants for the SHA-1 block hash.
// Holds the sequencer state type, the standard initial value, round constants
// and round functions. No dependencies.
package sha1_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_INIT_0 = 3'd0;
    localparam logic [2:0] CFG_INIT_1 = 3'd1;
    localparam logic [2:0] CFG_INIT_2 = 3'd2;
    localparam logic [2:0] CFG_INIT_3 = 3'd3;
    localparam logic [2:0] CFG_INIT_4 = 3'd4;

    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam logic [3:0] LAST_WORD   = 4'd15;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_DIGEST = 3'd4;

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hefcdab89;
    localparam logic [31:0] IV_2 = 32'h98badcfe;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hc3d2e1f0;

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        begin
            unique case (grp)
                2'd0:    k = 32'h5a827999;
                2'd1:    k = 32'h6ed9eba1;
                2'd2:    k = 32'h8f1bbcdc;
                default: k = 32'hca62c1d6;
            endcase
            return k;
        end
    endfunction

    // Ch, Parity, Maj, Parity by 20-round group
    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            case (grp)
                2'd0:    f = (b & c) ^ (~b & d);
                2'd2:    f = (b & c) ^ (b & d) ^ (c & d);
                default: f = b ^ c ^ d;
            endcase
            return f;
        end
    endfunction

endpackage

[rtl/sha1_block_hash.sv]
// SHA-1 compression over a pre-padded message, one 32-bit word per transaction.
// Depends on sha1_pkg for the state type, initial value and round functions.
//
// Usage: words 0..14 of a block are taken one per cycle while busy is low.
// Word 15 starts the compression: one round per cycle through a single shared
// round adder, 80 rounds and then a chaining-value update, with busy held high
// throughout. If word 15 carried message_end, five digest words follow on
// consecutive cycles, each marked by digest_valid for one cycle, with busy still
// high; the receiver must take them as they come. No new message words are
// taken until the compression and any digest output are done.
// The init registers are written through the cfg channel while idle and
// are picked up by the first block of the next message.
module sha1_block_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] message_word,
    input  logic        message_end,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic        digest_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sha1_pkg::state_t state_reg, state_next;

    logic [3:0]  widx_reg, widx_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        mid_reg, mid_next;
    logic        end_reg, end_next;

    logic [31:0] init_reg [sha1_pkg::HASH_WORDS];
    logic [31:0] cv_reg   [sha1_pkg::HASH_WORDS];
    logic [31:0] cv_next  [sha1_pkg::HASH_WORDS];
    logic [31:0] w_reg    [sha1_pkg::BLOCK_WORDS];
    logic [31:0] w_next   [sha1_pkg::BLOCK_WORDS];

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;

    logic        accept;
    logic        cfg_write;
    logic [1:0]  grp;
    logic [31:0] round_sum;
    logic [31:0] w_new;

    assign busy      = (state_reg != sha1_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == sha1_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Round group from the round counter
    always_comb
    begin
        if (cnt_reg < 7'd20)
            grp = 2'd0;
        else if (cnt_reg < 7'd40)
            grp = 2'd1;
        else if (cnt_reg < 7'd60)
            grp = 2'd2;
        else
            grp = 2'd3;
    end

    assign round_sum = {a_reg[26:0], a_reg[31:27]}
                     + sha1_pkg::round_f(grp, b_reg, c_reg, d_reg)
                     + e_reg + sha1_pkg::round_k(grp) + w_reg[0];

    // Next schedule word enters the top of the window
    assign w_new = {w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0] ^ w_reg[0][30:0],
                    w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (accept && widx_reg == sha1_pkg::LAST_WORD)
                    state_next = sha1_pkg::ST_ROUND;
            end
            sha1_pkg::ST_ROUND:
            begin
                if (cnt_reg == sha1_pkg::LAST_ROUND)
                    state_next = sha1_pkg::ST_UPDATE;
            end
            sha1_pkg::ST_UPDATE:
            begin
                state_next = end_reg ? sha1_pkg::ST_OUTPUT : sha1_pkg::ST_IDLE;
            end
            sha1_pkg::ST_OUTPUT:
            begin
                if (cnt_reg[2:0] == sha1_pkg::LAST_DIGEST)
                    state_next = sha1_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and counters
    always_comb
    begin
        widx_next = widx_reg;
        cnt_next  = cnt_reg;
        mid_next  = mid_reg;
        end_next  = end_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        cv_next   = cv_reg;
        w_next    = w_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
                        w_next[i] = w_reg[i + 1];
                    w_next[sha1_pkg::BLOCK_WORDS - 1] = message_word;
                    widx_next = widx_reg + 4'd1;
                    if (widx_reg == sha1_pkg::LAST_WORD)
                    begin
                        end_next = message_end;
                        cnt_next = '0;
                        // first block of a message starts from the init registers
                        if (!mid_reg)
                            cv_next = init_reg;
                        a_next = mid_reg ? cv_reg[0] : init_reg[0];
                        b_next = mid_reg ? cv_reg[1] : init_reg[1];
                        c_next = mid_reg ? cv_reg[2] : init_reg[2];
                        d_next = mid_reg ? cv_reg[3] : init_reg[3];
                        e_next = mid_reg ? cv_reg[4] : init_reg[4];
                    end
                end
            end
            sha1_pkg::ST_ROUND:
            begin
                a_next = round_sum;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
                    w_next[i] = w_reg[i + 1];
                w_next[sha1_pkg::BLOCK_WORDS - 1] = w_new;
                cnt_next = cnt_reg + 7'd1;
            end
            sha1_pkg::ST_UPDATE:
            begin
                cv_next[0] = cv_reg[0] + a_reg;
                cv_next[1] = cv_reg[1] + b_reg;
                cv_next[2] = cv_reg[2] + c_reg;
                cv_next[3] = cv_reg[3] + d_reg;
                cv_next[4] = cv_reg[4] + e_reg;
                mid_next   = 1'b1;
                cnt_next   = '0;
            end
            sha1_pkg::ST_OUTPUT:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[2:0] == sha1_pkg::LAST_DIGEST)
                    mid_next = 1'b0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        digest_valid = (state_reg == sha1_pkg::ST_OUTPUT);
        digest_last  = digest_valid && (cnt_reg[2:0] == sha1_pkg::LAST_DIGEST);
        digest_word  = cv_reg[cnt_reg[2:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::ST_IDLE;
            widx_reg  <= '0;
            cnt_reg   <= '0;
            mid_reg   <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            cnt_reg   <= cnt_next;
            mid_reg   <= mid_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg[0] <= sha1_pkg::IV_0;
            init_reg[1] <= sha1_pkg::IV_1;
            init_reg[2] <= sha1_pkg::IV_2;
            init_reg[3] <= sha1_pkg::IV_3;
            init_reg[4] <= sha1_pkg::IV_4;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sha1_pkg::CFG_INIT_0: init_reg[0] <= cfg_data;
                sha1_pkg::CFG_INIT_1: init_reg[1] <= cfg_data;
                sha1_pkg::CFG_INIT_2: init_reg[2] <= cfg_data;
                sha1_pkg::CFG_INIT_3: init_reg[3] <= cfg_data;
                sha1_pkg::CFG_INIT_4: init_reg[4] <= cfg_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        d_reg  <= d_next;
        e_reg  <= e_next;
        cv_reg <= cv_next;
        w_reg  <= w_next;
    end

    // Last word of a block always starts a compression
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && widx_reg == sha1_pkg::LAST_WORD |=> busy && cnt_reg == 7'd0)
        else $error("compression did not start after last block word");

    // Digest words come as an unbroken burst
    a_digest_burst: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_last |=> digest_valid)
        else $error("digest burst broken");

    // Block is free again right after the final digest word
    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        digest_last |=> !busy && !mid_reg)
        else $error("block still busy after final digest word");

    // Round counter stays within the round range
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1_pkg::ST_ROUND |-> cnt_reg <= sha1_pkg::LAST_ROUND)
        else $error("round counter out of range");

    // Compression leaves the message marked as in progress
    a_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1_pkg::ST_UPDATE |=> mid_reg)
        else $error("chaining value update did not mark the message");

endmodule
